>>> hw/rtl/first_fit_heap_allocator_top_assert.svh
// Assertion macros for the first-fit heap allocator checks
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// checked only out of reset
`define FFHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ffha assertion failed");

// checked at every edge, reset included
`define FFHA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("ffha assertion failed");

`endif

>>> hw/rtl/ffha_pkg.sv
// Shared constants, codes and types of the first-fit heap allocator
package ffha_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned ADDRESS_BITS = 32;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [2:0] {
    ST_REUSED  = 3'd0,
    ST_GROWN   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_NOROOM  = 3'd3,
    ST_TRIMMED = 3'd4,
    ST_MARKED  = 3'd5,
    ST_NULL    = 3'd6,
    ST_UNKNOWN = 3'd7
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [DATA_W-1:0] heap_base;
    logic [DATA_W-1:0] heap_limit;
    logic              base_load;
  } cfg_t;

endpackage

>>> hw/rtl/ffha_ram.sv
// Block table memory: one write port, one registered read port
module ffha_ram #(
  parameter int unsigned DEPTH = ffha_pkg::MAX_BLOCKS,
  parameter int unsigned WIDTH = 2 * ffha_pkg::DATA_W,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/ffha_ctrl.sv
// Allocator sequencer: table scan, grow, trim and result register
module ffha_ctrl #(
  parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS,
  localparam int unsigned IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int unsigned DW        = ffha_pkg::DATA_W,
  localparam int unsigned ENT_W     = 2 * DW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ffha_pkg::cfg_t          cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [DW-1:0]           alloc_size_i,
  input  logic [DW-1:0]           free_address_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DW-1:0]           result_address_o,
  output ffha_pkg::status_e       status_o,
  output logic                    ram_rd_en_o,
  output logic [IDX_W-1:0]        ram_rd_addr_o,
  input  logic [ENT_W-1:0]        ram_rd_data_i,
  output logic                    ram_wr_en_o,
  output logic [IDX_W-1:0]        ram_wr_addr_o,
  output logic [ENT_W-1:0]        ram_wr_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SUM_W = DW + 2;
  localparam logic [SUM_W-1:0] HDR = SUM_W'(ffha_pkg::HEADER_BYTES);
  localparam logic [SUM_W-1:0] ADDR_MASK = (ffha_pkg::ADDRESS_BITS >= SUM_W) ? '1 :
    SUM_W'((64'd1 << ffha_pkg::ADDRESS_BITS) - 64'd1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic              cmd_q, cmd_d;
  logic [DW-1:0]     size_q, size_d;
  logic [DW-1:0]     faddr_q, faddr_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DW-1:0]     break_q, break_d;
  logic [MAX_BLOCKS-1:0] free_q, free_d;
  logic [DW-1:0]     pend_addr_q, pend_addr_d;
  ffha_pkg::status_e pend_status_q, pend_status_d;
  logic              out_valid_q, out_valid_d;
  logic [DW-1:0]     res_addr_q, res_addr_d;
  ffha_pkg::status_e res_status_q, res_status_d;

  logic [DW-1:0]    ent_size, ent_payload;
  logic [SUM_W-1:0] grow_sum, limit_ext, top_addr, drop;
  logic [DW-1:0]    grow_payload, trim_break;
  logic             hit, is_last, table_full;

  assign ent_size     = ram_rd_data_i[ENT_W-1:DW];
  assign ent_payload  = ram_rd_data_i[DW-1:0];
  assign grow_sum     = {2'b00, break_q} + HDR + {2'b00, size_q};
  assign grow_payload = break_q + HDR[DW-1:0];
  assign limit_ext    = {2'b00, cfg_i.heap_limit};
  assign top_addr     = (limit_ext < ADDR_MASK) ? limit_ext : ADDR_MASK;
  assign drop         = {2'b00, ent_size} + HDR;
  assign trim_break   = ({2'b00, break_q} >= drop) ? (break_q - drop[DW-1:0])
                                                   : cfg_i.heap_base;
  assign table_full   = count_q >= CNT_W'(MAX_BLOCKS);
  assign is_last      = (CNT_W'(chk_idx_q) + CNT_W'(1)) == count_q;
  assign hit = chk_vld_q && ((cmd_q == ffha_pkg::CMD_ALLOC)
             ? (free_q[chk_idx_q] && (ent_size >= size_q))
             : (ent_payload == faddr_q));

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_address_o = res_addr_q;
  assign status_o         = res_status_q;
  assign ram_rd_addr_o    = rd_idx_q[IDX_W-1:0];
  assign ram_wr_addr_o    = count_q[IDX_W-1:0];
  assign ram_wr_data_o    = {size_q, grow_payload};

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    size_d        = size_q;
    faddr_d       = faddr_q;
    rd_idx_d      = rd_idx_q;
    chk_vld_d     = chk_vld_q;
    chk_idx_d     = chk_idx_q;
    count_d       = count_q;
    break_d       = break_q;
    free_d        = free_q;
    pend_addr_d   = pend_addr_q;
    pend_status_d = pend_status_q;
    out_valid_d   = out_valid_q;
    res_addr_d    = res_addr_q;
    res_status_d  = res_status_q;
    ram_rd_en_o   = 1'b0;
    ram_wr_en_o   = 1'b0;

    if (cfg_i.base_load && (count_q == '0)) begin
      break_d = cfg_i.heap_base;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = cmd_i;
          size_d      = alloc_size_i;
          faddr_d     = free_address_i;
          rd_idx_d    = '0;
          chk_vld_d   = 1'b0;
          pend_addr_d = '0;
          if ((cmd_i == ffha_pkg::CMD_ALLOC) && (alloc_size_i == '0)) begin
            pend_status_d = ffha_pkg::ST_ZERO;
            state_d       = S_DONE;
          end else if ((cmd_i == ffha_pkg::CMD_FREE) && (free_address_i == '0)) begin
            pend_status_d = ffha_pkg::ST_NULL;
            state_d       = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          chk_vld_d = 1'b0;
          state_d   = S_DONE;
          if (cmd_q == ffha_pkg::CMD_ALLOC) begin
            free_d[chk_idx_q] = 1'b0;
            pend_addr_d       = ent_payload;
            pend_status_d     = ffha_pkg::ST_REUSED;
          end else if (is_last) begin
            // popping the top block lowers the break
            free_d[chk_idx_q] = 1'b0;
            count_d           = CNT_W'(chk_idx_q);
            break_d           = trim_break;
            pend_status_d     = ffha_pkg::ST_TRIMMED;
          end else begin
            free_d[chk_idx_q] = 1'b1;
            pend_status_d     = ffha_pkg::ST_MARKED;
          end
        end else if (rd_idx_q >= count_q) begin
          chk_vld_d = 1'b0;
          state_d   = S_DONE;
          if (cmd_q == ffha_pkg::CMD_FREE) begin
            pend_status_d = ffha_pkg::ST_UNKNOWN;
          end else if (table_full || (grow_sum > top_addr)) begin
            pend_status_d = ffha_pkg::ST_NOROOM;
          end else begin
            ram_wr_en_o                 = 1'b1;
            free_d[count_q[IDX_W-1:0]] = 1'b0;
            count_d                     = count_q + CNT_W'(1);
            break_d                     = grow_sum[DW-1:0];
            pend_addr_d                 = grow_payload;
            pend_status_d               = ffha_pkg::ST_GROWN;
          end
        end else begin
          ram_rd_en_o = 1'b1;
          rd_idx_d    = rd_idx_q + CNT_W'(1);
          chk_vld_d   = 1'b1;
          chk_idx_d   = rd_idx_q[IDX_W-1:0];
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          res_addr_d   = pend_addr_q;
          res_status_d = pend_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= 1'b0;
      size_q        <= '0;
      faddr_q       <= '0;
      rd_idx_q      <= '0;
      chk_vld_q     <= 1'b0;
      chk_idx_q     <= '0;
      count_q       <= '0;
      break_q       <= '0;
      free_q        <= '0;
      pend_addr_q   <= '0;
      pend_status_q <= ffha_pkg::ST_REUSED;
      out_valid_q   <= 1'b0;
      res_addr_q    <= '0;
      res_status_q  <= ffha_pkg::ST_REUSED;
    end else begin
      state_q       <= state_d;
      cmd_q         <= cmd_d;
      size_q        <= size_d;
      faddr_q       <= faddr_d;
      rd_idx_q      <= rd_idx_d;
      chk_vld_q     <= chk_vld_d;
      chk_idx_q     <= chk_idx_d;
      count_q       <= count_d;
      break_q       <= break_d;
      free_q        <= free_d;
      pend_addr_q   <= pend_addr_d;
      pend_status_q <= pend_status_d;
      out_valid_q   <= out_valid_d;
      res_addr_q    <= res_addr_d;
      res_status_q  <= res_status_d;
    end
  end

endmodule

>>> hw/rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator: a table of blocks in creation order, one entry per memory
// word, searched first-fit for allocate and by payload address for free. One word is
// taken at a time; an allocate or free that scans the table reads the table memory one
// entry per cycle; a zero-size allocate or a null free skips the scan. A new word is
// taken while a finished result still waits on the output. No clearing pass follows
// reset. The user must write heap_base and heap_limit only while the block is idle; the
// block itself does not enforce it.
module first_fit_heap_allocator_top #(
  parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] alloc_size_i,
  input  logic [31:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_address_o,
  output logic [2:0]  status_o
);

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned ENT_W = 2 * ffha_pkg::DATA_W;

  logic [31:0]       heap_base_q, heap_base_d;
  logic [31:0]       heap_limit_q, heap_limit_d;
  ffha_pkg::cfg_t    cfg;
  ffha_pkg::status_e status;
  logic              ram_rd_en, ram_wr_en;
  logic [IDX_W-1:0]  ram_rd_addr, ram_wr_addr;
  logic [ENT_W-1:0]  ram_rd_data, ram_wr_data;

  always_comb begin
    heap_base_d  = heap_base_q;
    heap_limit_d = heap_limit_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ffha_pkg::REG_HEAP_BASE:  heap_base_d  = cfg_wdata_i;
        ffha_pkg::REG_HEAP_LIMIT: heap_limit_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      heap_limit_q <= '1;
    end else begin
      heap_base_q  <= heap_base_d;
      heap_limit_q <= heap_limit_d;
    end
  end

  assign cfg.heap_base  = heap_base_d;
  assign cfg.heap_limit = heap_limit_q;
  assign cfg.base_load  = cfg_we_i && (cfg_index_i == ffha_pkg::REG_HEAP_BASE);
  assign status_o       = status;

  ffha_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .alloc_size_i     (alloc_size_i),
    .free_address_i   (free_address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_address_o (result_address_o),
    .status_o         (status),
    .ram_rd_en_o      (ram_rd_en),
    .ram_rd_addr_o    (ram_rd_addr),
    .ram_rd_data_i    (ram_rd_data),
    .ram_wr_en_o      (ram_wr_en),
    .ram_wr_addr_o    (ram_wr_addr),
    .ram_wr_data_o    (ram_wr_data)
  );

  ffha_ram #(
    .DEPTH(MAX_BLOCKS),
    .WIDTH(ENT_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data)
  );

endmodule

>>> hw/rtl/ffha_checker.sv
// Port-level checks of the first-fit heap allocator, bound to the top level
`include "first_fit_heap_allocator_top_assert.svh"

module ffha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_address_o,
  input logic [2:0]  status_o
);

  logic handed_out;

  assign handed_out = (status_o == ffha_pkg::ST_REUSED) || (status_o == ffha_pkg::ST_GROWN);

  // one word in flight: ready drops once a word is taken
  `FFHA_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o)

  // only a handed-out block carries an address
  `FFHA_ASSERT(a_null_addr, (out_valid_o && !handed_out) |-> (result_address_o == '0))

  // a handed-out address lies past the first header
  `FFHA_ASSERT(a_live_addr, (out_valid_o && handed_out) |-> (result_address_o != '0))

  `FFHA_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_address_o) && $stable(status_o)))

  // an edge under reset leaves the output empty
  `FFHA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o)

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (.*);
